[src/rc4k_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rc4k_pkg;

    // Fixed sizes of the permutation and of the key transaction.
    localparam int PERM_SIZE        = 256;
    localparam int KEY_FIELDS       = 5;
    localparam int KF_W             = 3;
    localparam int MAX_RESULTS      = 8;
    localparam int K_W              = 3;
    localparam int KEY_LENGTH_DEF   = 5;
    localparam int OUTPUT_BYTES_DEF = 8;
    localparam int UPC_W            = 5;

    // Datapath selector and operation codes.
    typedef enum logic [1:0] {RD_P, RD_J, RD_I, RD_T} rd_sel_t;
    typedef enum logic [1:0] {WA_P, WA_J, WA_I} wa_sel_t;
    typedef enum logic [1:0] {WD_P, WD_RDATA, WD_A} wd_sel_t;
    typedef enum logic [1:0] {J_HOLD, J_CLR, J_KSA, J_GEN} j_op_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_t;
    typedef enum logic [2:0] {
        COND_NEVER, COND_ALWAYS, COND_NO_INPUT, COND_P_MORE, COND_OUT_BUSY, COND_K_LAST
    } cond_t;

    // Control word fields that drive the datapath.
    typedef struct packed {
        rd_sel_t rd_sel;
        logic    we;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        j_op_t   j_op;
        cnt_op_t i_op;
        cnt_op_t k_op;
        logic    a_load;
        logic    b_load;
        logic    p_inc;
        logic    kpos_inc;
        logic    key_load;
    } ctrl_t;

    // Flags the datapath reports back to the sequencer.
    typedef struct packed {
        logic p_more;
        logic k_last;
    } status_t;

    // One full microcode word.
    typedef struct packed {
        ctrl_t                dp;
        logic                 take;
        logic                 emit;
        cond_t                cond;
        logic [UPC_W-1:0]     target;
    } ucode_t;

    // Program addresses.
    localparam logic [UPC_W-1:0] S_IDLE     = 5'd0;
    localparam logic [UPC_W-1:0] S_FILL     = 5'd1;
    localparam logic [UPC_W-1:0] S_KSA_RD   = 5'd2;
    localparam logic [UPC_W-1:0] S_KSA_J    = 5'd3;
    localparam logic [UPC_W-1:0] S_KSA_RDJ  = 5'd4;
    localparam logic [UPC_W-1:0] S_KSA_W1   = 5'd5;
    localparam logic [UPC_W-1:0] S_KSA_W2   = 5'd6;
    localparam logic [UPC_W-1:0] S_GEN_INIT = 5'd7;
    localparam logic [UPC_W-1:0] S_GEN_I    = 5'd8;
    localparam logic [UPC_W-1:0] S_GEN_RDI  = 5'd9;
    localparam logic [UPC_W-1:0] S_GEN_J    = 5'd10;
    localparam logic [UPC_W-1:0] S_GEN_RDJ  = 5'd11;
    localparam logic [UPC_W-1:0] S_GEN_W1   = 5'd12;
    localparam logic [UPC_W-1:0] S_GEN_W2   = 5'd13;
    localparam logic [UPC_W-1:0] S_GEN_RDT  = 5'd14;
    localparam logic [UPC_W-1:0] S_GEN_OUT  = 5'd15;
    localparam logic [UPC_W-1:0] S_GEN_NEXT = 5'd16;
    localparam logic [UPC_W-1:0] S_GEN_LOOP = 5'd17;

    // The microprogram. Jumps go to target when the condition holds,
    // otherwise the step counter advances by one.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucode_t w;
        w.dp.rd_sel   = RD_P;
        w.dp.we       = 1'b0;
        w.dp.wa_sel   = WA_P;
        w.dp.wd_sel   = WD_P;
        w.dp.j_op     = J_HOLD;
        w.dp.i_op     = CNT_HOLD;
        w.dp.k_op     = CNT_HOLD;
        w.dp.a_load   = 1'b0;
        w.dp.b_load   = 1'b0;
        w.dp.p_inc    = 1'b0;
        w.dp.kpos_inc = 1'b0;
        w.dp.key_load = 1'b0;
        w.take        = 1'b0;
        w.emit        = 1'b0;
        w.cond        = COND_NEVER;
        w.target      = S_IDLE;
        case (upc)
            S_IDLE:
            begin
                w.take        = 1'b1;
                w.dp.key_load = 1'b1;
                w.cond        = COND_NO_INPUT;
                w.target      = S_IDLE;
            end
            S_FILL:
            begin
                w.dp.we     = 1'b1;
                w.dp.wa_sel = WA_P;
                w.dp.wd_sel = WD_P;
                w.dp.p_inc  = 1'b1;
                w.cond      = COND_P_MORE;
                w.target    = S_FILL;
            end
            S_KSA_RD:
            begin
                w.dp.rd_sel = RD_P;
            end
            S_KSA_J:
            begin
                w.dp.j_op   = J_KSA;
                w.dp.a_load = 1'b1;
            end
            S_KSA_RDJ:
            begin
                w.dp.rd_sel = RD_J;
            end
            S_KSA_W1:
            begin
                w.dp.we     = 1'b1;
                w.dp.wa_sel = WA_P;
                w.dp.wd_sel = WD_RDATA;
            end
            S_KSA_W2:
            begin
                w.dp.we       = 1'b1;
                w.dp.wa_sel   = WA_J;
                w.dp.wd_sel   = WD_A;
                w.dp.p_inc    = 1'b1;
                w.dp.kpos_inc = 1'b1;
                w.cond        = COND_P_MORE;
                w.target      = S_KSA_RD;
            end
            S_GEN_INIT:
            begin
                w.dp.j_op = J_CLR;
                w.dp.i_op = CNT_CLR;
                w.dp.k_op = CNT_CLR;
            end
            S_GEN_I:
            begin
                w.dp.i_op = CNT_INC;
            end
            S_GEN_RDI:
            begin
                w.dp.rd_sel = RD_I;
            end
            S_GEN_J:
            begin
                w.dp.j_op   = J_GEN;
                w.dp.a_load = 1'b1;
            end
            S_GEN_RDJ:
            begin
                w.dp.rd_sel = RD_J;
            end
            S_GEN_W1:
            begin
                w.dp.we     = 1'b1;
                w.dp.wa_sel = WA_I;
                w.dp.wd_sel = WD_RDATA;
                w.dp.b_load = 1'b1;
            end
            S_GEN_W2:
            begin
                w.dp.we     = 1'b1;
                w.dp.wa_sel = WA_J;
                w.dp.wd_sel = WD_A;
            end
            S_GEN_RDT:
            begin
                w.dp.rd_sel = RD_T;
            end
            S_GEN_OUT:
            begin
                // Keep reading the output entry so the byte survives a stall.
                w.dp.rd_sel = RD_T;
                w.emit      = 1'b1;
                w.cond      = COND_OUT_BUSY;
                w.target    = S_GEN_OUT;
            end
            S_GEN_NEXT:
            begin
                w.dp.k_op = CNT_INC;
                w.cond    = COND_K_LAST;
                w.target  = S_IDLE;
            end
            S_GEN_LOOP:
            begin
                w.cond   = COND_ALWAYS;
                w.target = S_GEN_I;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/rc4k_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Key channel: one transaction carries a five-byte key.
interface rc4k_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte_0;
    logic [7:0] key_byte_1;
    logic [7:0] key_byte_2;
    logic [7:0] key_byte_3;
    logic [7:0] key_byte_4;

    modport source (
        output valid, key_byte_0, key_byte_1, key_byte_2, key_byte_3, key_byte_4,
        input  ready
    );
    modport sink (
        input  valid, key_byte_0, key_byte_1, key_byte_2, key_byte_3, key_byte_4,
        output ready
    );
endinterface

// Keystream channel: one transaction carries one keystream byte.
interface rc4k_ks_if;
    logic       valid;
    logic       ready;
    logic [7:0] keystream_byte;
    logic       last_byte;

    modport source (
        output valid, keystream_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, keystream_byte, last_byte,
        output ready
    );
endinterface

`default_nettype wire

[src/rc4k_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rc4k_datapath #(
    parameter int KEY_LENGTH   = rc4k_pkg::KEY_LENGTH_DEF,
    parameter int OUTPUT_BYTES = rc4k_pkg::OUTPUT_BYTES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rc4k_pkg::ctrl_t ctrl,
    input  wire logic [7:0]      key_byte_0,
    input  wire logic [7:0]      key_byte_1,
    input  wire logic [7:0]      key_byte_2,
    input  wire logic [7:0]      key_byte_3,
    input  wire logic [7:0]      key_byte_4,
    output rc4k_pkg::status_t    status,
    output logic [7:0]           rdata
);
    import rc4k_pkg::*;

    localparam int KEY_PERIOD = (KEY_LENGTH < 1) ? 1 : KEY_LENGTH;
    localparam int KPOS_W     = (KEY_PERIOD > 1) ? $clog2(KEY_PERIOD) : 1;
    localparam int N_OUT      = (OUTPUT_BYTES < 1) ? 1 :
                                ((OUTPUT_BYTES > MAX_RESULTS) ? MAX_RESULTS : OUTPUT_BYTES);

    logic [7:0]        perm_mem [PERM_SIZE];
    logic [7:0]        rdata_reg;
    logic [7:0]        key_reg [KEY_FIELDS];
    logic [7:0]        p_reg, p_next;
    logic [7:0]        j_reg, j_next;
    logic [7:0]        i_reg, i_next;
    logic [7:0]        a_reg, b_reg;
    logic [K_W-1:0]    k_reg, k_next;
    logic [KPOS_W-1:0] kpos_reg, kpos_next;
    logic [KF_W-1:0]   kfield_reg, kfield_next;
    logic [7:0]        rd_addr, wr_addr, wr_data;

    // Permutation memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            perm_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= perm_mem[rd_addr];
    end

    assign rdata = rdata_reg;

    // Address and write-data selection.
    always_comb
    begin
        case (ctrl.rd_sel)
            RD_P:    rd_addr = p_reg;
            RD_J:    rd_addr = j_reg;
            RD_I:    rd_addr = i_reg;
            RD_T:    rd_addr = a_reg + b_reg;
            default: rd_addr = p_reg;
        endcase
        case (ctrl.wa_sel)
            WA_P:    wr_addr = p_reg;
            WA_J:    wr_addr = j_reg;
            WA_I:    wr_addr = i_reg;
            default: wr_addr = p_reg;
        endcase
        case (ctrl.wd_sel)
            WD_P:     wr_data = p_reg;
            WD_RDATA: wr_data = rdata_reg;
            WD_A:     wr_data = a_reg;
            default:  wr_data = p_reg;
        endcase
    end

    // Index registers and key position counters.
    always_comb
    begin
        p_next      = p_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        kpos_next   = kpos_reg;
        kfield_next = kfield_reg;
        if (ctrl.key_load)
        begin
            p_next      = 8'd0;
            j_next      = 8'd0;
            kpos_next   = '0;
            kfield_next = '0;
        end
        else
        begin
            if (ctrl.p_inc)
            begin
                p_next = p_reg + 8'd1;
            end
            if (ctrl.kpos_inc)
            begin
                // Key position runs over the key period; the field wraps every five.
                if (kpos_reg == KPOS_W'(KEY_PERIOD - 1))
                begin
                    kpos_next   = '0;
                    kfield_next = '0;
                end
                else
                begin
                    kpos_next = kpos_reg + KPOS_W'(1);
                    if (kfield_reg == KF_W'(KEY_FIELDS - 1))
                    begin
                        kfield_next = '0;
                    end
                    else
                    begin
                        kfield_next = kfield_reg + KF_W'(1);
                    end
                end
            end
            case (ctrl.j_op)
                J_HOLD:  j_next = j_reg;
                J_CLR:   j_next = 8'd0;
                J_KSA:   j_next = j_reg + rdata_reg + key_reg[kfield_reg];
                J_GEN:   j_next = j_reg + rdata_reg;
                default: j_next = j_reg;
            endcase
        end
        case (ctrl.i_op)
            CNT_HOLD: i_next = i_reg;
            CNT_CLR:  i_next = 8'd0;
            CNT_INC:  i_next = i_reg + 8'd1;
            default:  i_next = i_reg;
        endcase
        case (ctrl.k_op)
            CNT_HOLD: k_next = k_reg;
            CNT_CLR:  k_next = '0;
            CNT_INC:  k_next = k_reg + K_W'(1);
            default:  k_next = k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg      <= 8'd0;
            j_reg      <= 8'd0;
            i_reg      <= 8'd0;
            k_reg      <= '0;
            kpos_reg   <= '0;
            kfield_reg <= '0;
        end
        else
        begin
            p_reg      <= p_next;
            j_reg      <= j_next;
            i_reg      <= i_next;
            k_reg      <= k_next;
            kpos_reg   <= kpos_next;
            kfield_reg <= kfield_next;
        end
    end

    // Key bytes and swap temporaries carry no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.key_load)
        begin
            key_reg[0] <= key_byte_0;
            key_reg[1] <= key_byte_1;
            key_reg[2] <= key_byte_2;
            key_reg[3] <= key_byte_3;
            key_reg[4] <= key_byte_4;
        end
        if (ctrl.a_load)
        begin
            a_reg <= rdata_reg;
        end
        if (ctrl.b_load)
        begin
            b_reg <= rdata_reg;
        end
    end

    assign status.p_more = (p_reg != 8'd255);
    assign status.k_last = (k_reg == K_W'(N_OUT - 1));

endmodule

`default_nettype wire

[src/rc4_keystream_generator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// RC4 keystream generator.
// key_in takes one transaction per key (five bytes). For each key the block
// fills its 256-entry permutation with the identity, runs the 256 key
// scheduling swaps and then produces OUTPUT_BYTES (clamped to 1..8)
// keystream bytes on ks_out, one transaction each, with last_byte set on
// the final one. Every key starts afresh; nothing carries over from the
// previous key. A small microprogram steps one permutation memory with
// one read and one write port: the fill writes the identity entry by
// entry, each scheduling swap reads entry p, updates j, reads entry j
// and writes both entries, and each output byte steps i, swaps entries
// i and j and reads the entry at the sum of the two swapped values.
// key_in.ready is high only while the block is idle; the next key may be
// taken while the last byte of the previous key still waits in the output
// register. When the receiver stalls, the sequencer waits at the output
// step and no data is lost. Reset clears the sequencer and the output
// valid flag; the permutation memory is simply overwritten by each key.
module rc4_keystream_generator_unit #(
    parameter int KEY_LENGTH   = rc4k_pkg::KEY_LENGTH_DEF,
    parameter int OUTPUT_BYTES = rc4k_pkg::OUTPUT_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rc4k_key_if.sink    key_in,
    rc4k_ks_if.source   ks_out
);
    import rc4k_pkg::*;

    logic [UPC_W-1:0] upc_reg, upc_next;
    ucode_t           uword;
    ctrl_t            dp_ctrl;
    status_t          status;
    logic [7:0]       rdata;
    logic             out_busy;
    logic             emit_fire;
    logic             jump;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    // Fetch the current control word.
    assign uword = ucode_rom(upc_reg);

    // The key is loaded only on an accepted transaction.
    always_comb
    begin
        dp_ctrl          = uword.dp;
        dp_ctrl.key_load = uword.dp.key_load && key_in.valid;
    end

    assign key_in.ready = uword.take;
    assign out_busy     = out_valid_reg && !ks_out.ready;
    assign emit_fire    = uword.emit && !out_busy;

    // Branch condition and step counter.
    always_comb
    begin
        case (uword.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !key_in.valid;
            COND_P_MORE:   jump = status.p_more;
            COND_OUT_BUSY: jump = out_busy;
            COND_K_LAST:   jump = status.k_last;
            default:       jump = 1'b0;
        endcase
        upc_next = jump ? uword.target : upc_reg + UPC_W'(1);
    end

    // Output register frees on a completed transaction, loads on emit.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ks_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_byte_reg <= rdata;
            out_last_reg <= status.k_last;
        end
    end

    assign ks_out.valid          = out_valid_reg;
    assign ks_out.keystream_byte = out_byte_reg;
    assign ks_out.last_byte      = out_last_reg;

    rc4k_datapath #(
        .KEY_LENGTH   (KEY_LENGTH),
        .OUTPUT_BYTES (OUTPUT_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dp_ctrl),
        .key_byte_0 (key_in.key_byte_0),
        .key_byte_1 (key_in.key_byte_1),
        .key_byte_2 (key_in.key_byte_2),
        .key_byte_3 (key_in.key_byte_3),
        .key_byte_4 (key_in.key_byte_4),
        .status     (status),
        .rdata      (rdata)
    );

endmodule

`default_nettype wire

[src/rc4k_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rc4k_checker #(
    parameter int OUTPUT_BYTES = rc4k_pkg::OUTPUT_BYTES_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);
    import rc4k_pkg::*;

    localparam int N_OUT = (OUTPUT_BYTES < 1) ? 1 :
                           ((OUTPUT_BYTES > MAX_RESULTS) ? MAX_RESULTS : OUTPUT_BYTES);

    logic           in_acc, out_acc;
    logic [K_W-1:0] cnt_reg, cnt_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count keystream transactions within one key.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (out_acc)
        begin
            cnt_next = out_last ? '0 : cnt_reg + K_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled keystream transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("keystream transaction changed while stalled");

    // The key setup follows each accepted key, so keys never arrive back to back.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("second key taken right after the first");

    // The final byte of a key is exactly the last of its keystream.
    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && out_last |-> cnt_reg == K_W'(N_OUT - 1))
        else $error("last mark on the wrong keystream byte");

    a_last_missing: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !out_last |-> cnt_reg != K_W'(N_OUT - 1))
        else $error("last mark missing on the final keystream byte");

    // Once reset has been seen at an edge, no keystream is offered.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("keystream valid during reset");

endmodule

bind rc4_keystream_generator_unit rc4k_checker #(
    .OUTPUT_BYTES (OUTPUT_BYTES)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (key_in.valid),
    .in_ready  (key_in.ready),
    .out_valid (ks_out.valid),
    .out_ready (ks_out.ready),
    .out_byte  (ks_out.keystream_byte),
    .out_last  (ks_out.last_byte)
);

`default_nettype wire
